### rtl/imu_cal_pkg.sv
//------------------------------------------------------------------------------
// imu_cal_pkg
// Shared types and constants for the IMU offset calibrator.
//------------------------------------------------------------------------------
package imu_cal_pkg;

  localparam int COUNT_BITS = 16;
  localparam int AXES       = 6;
  localparam int SUM_W      = 33;
  localparam int QDEPTH     = 2;

  localparam logic signed [31:0] GRAVITY  = 32'sd16384;
  localparam logic [15:0]        GYRO_Q16 = 16'd16393;
  localparam logic [16:0]        BEST_RESET = 17'd32768;

  localparam logic [2:0] REG_ROUND = 3'd0;

  typedef logic signed [15:0] s16_t;

  typedef struct packed {
    logic start;
    s16_t [AXES-1:0] smp;
  } item_t;

  typedef struct packed {
    s16_t [AXES-1:0] off;
    logic [AXES-1:0] mask;
  } result_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

### rtl/imu_cal_front.sv
//------------------------------------------------------------------------------
// imu_cal_front
// Accepts sample items into a short queue for the back end.
//------------------------------------------------------------------------------
module imu_cal_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  imu_cal_pkg::item_t   in_item,
  output logic                 q_valid,
  input  logic                 q_pop,
  output imu_cal_pkg::item_t   q_item
);
  imu_cal_pkg::item_t mem_r [imu_cal_pkg::QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'(imu_cal_pkg::QDEPTH));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_pop};
    end
  end
endmodule

### rtl/imu_cal_div.sv
//------------------------------------------------------------------------------
// imu_cal_div
// Restoring divider: signed 33-bit sum by unsigned count, one bit per cycle.
//------------------------------------------------------------------------------
module imu_cal_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [imu_cal_pkg::SUM_W-1:0]   num,
  input  logic [imu_cal_pkg::COUNT_BITS-1:0]     den,
  output logic                                   done,
  output logic signed [31:0]                     quo
);
  localparam int W = imu_cal_pkg::SUM_W;
  logic [W-1:0] q_r;
  logic [imu_cal_pkg::COUNT_BITS:0] rem_r;
  logic [5:0] n_r;
  logic neg_r, busy_r;
  logic [imu_cal_pkg::COUNT_BITS:0] trial;
  logic [W-1:0] qres;

  assign trial = {rem_r[imu_cal_pkg::COUNT_BITS-1:0], q_r[W-1]};
  assign done  = busy_r && (n_r == 6'd0);
  assign qres  = neg_r ? (~q_r + 1'b1) : q_r;
  assign quo   = qres[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; n_r <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      n_r    <= 6'(W);
      neg_r  <= num[W-1];
      q_r    <= num[W-1] ? (~num + 1'b1) : num;
      rem_r  <= '0;
    end else if (busy_r && n_r != 6'd0) begin
      n_r <= n_r - 6'd1;
      if (trial >= {1'b0, den}) begin
        rem_r <= trial - {1'b0, den};
        q_r   <= {q_r[W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[W-2:0], 1'b0};
      end
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end
endmodule

### rtl/imu_cal_back.sv
//------------------------------------------------------------------------------
// imu_cal_back
// Accumulates sums, ends rounds, updates bests and offsets, holds result.
//------------------------------------------------------------------------------
module imu_cal_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  imu_cal_pkg::item_t                  q_item,
  input  logic [15:0]                         round_samples,
  input  imu_cal_pkg::s16_t [imu_cal_pkg::AXES-1:0] init_off,
  output logic                                out_valid,
  input  logic                                out_ready,
  output imu_cal_pkg::result_t                out_res
);
  localparam int A = imu_cal_pkg::AXES;
  localparam int CB = imu_cal_pkg::COUNT_BITS;
  localparam int SW = imu_cal_pkg::SUM_W;

  imu_cal_pkg::state_t st_r, st_nxt;
  logic signed [SW-1:0] sum_r [A];
  logic [CB-1:0] cnt_r;
  logic [16:0] best_r [A];
  imu_cal_pkg::s16_t off_r [A];
  logic [A-1:0] mask_r;
  logic [2:0] ax_r;
  logic ov_r;
  logic div_go;
  logic div_done;
  logic signed [31:0] avg;

  logic [CB-1:0] limit, cnt_new;
  logic [CB:0] lim_w;
  logic signed [SW-1:0] sum_new [A];
  logic take;

  always_comb begin
    lim_w = (round_samples == 16'd0) ? (CB+1)'(1) : (CB+1)'(round_samples);
    if (lim_w > (CB+1)'({CB{1'b1}})) lim_w = (CB+1)'({CB{1'b1}});
    limit = lim_w[CB-1:0];
  end

  assign take  = (st_r == imu_cal_pkg::ST_ACC) && q_valid;
  assign q_pop = take;
  assign cnt_new = (q_item.start ? CB'(0) : cnt_r) + CB'(1);

  always_comb begin
    for (int i = 0; i < A; i++)
      sum_new[i] = (q_item.start ? SW'(0) : sum_r[i]) + SW'(q_item.smp[i]);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      imu_cal_pkg::ST_ACC: if (take && cnt_new >= limit) st_nxt = imu_cal_pkg::ST_DIV;
      imu_cal_pkg::ST_DIV: if (div_done) st_nxt = imu_cal_pkg::ST_UPD;
      imu_cal_pkg::ST_UPD:
        st_nxt = (ax_r == 3'(A-1)) ? imu_cal_pkg::ST_OUT : imu_cal_pkg::ST_DIV;
      imu_cal_pkg::ST_OUT: st_nxt = ov_r ? imu_cal_pkg::ST_OUT : imu_cal_pkg::ST_ACC;
      default: st_nxt = imu_cal_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    div_go = 1'b0;
    case (st_r)
      imu_cal_pkg::ST_ACC: div_go = take && cnt_new >= limit;
      imu_cal_pkg::ST_UPD: div_go = (ax_r != 3'(A-1));
      default: div_go = 1'b0;
    endcase
  end

  imu_cal_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go),
    .num(take ? sum_new[0] : sum_r[(ax_r == 3'(A-1)) ? 3'd0 : ax_r + 3'd1]),
    .den(cnt_r), .done(div_done), .quo(avg)
  );

  logic [31:0] mag, mag_r;
  logic signed [31:0] neg, negz, delta, delta_r, nsum;
  logic [31:0] gprod;
  logic signed [31:0] gq;
  always_comb begin
    mag  = avg[31] ? 32'(-avg) : 32'(avg);
    neg  = -avg;
    negz = (neg < 0) ? neg + imu_cal_pkg::GRAVITY : neg - imu_cal_pkg::GRAVITY;
    gprod = mag * 32'(imu_cal_pkg::GYRO_Q16);
    gq = 32'(gprod[31:16]);
    if (ax_r < 3'd2) delta = neg / 8;
    else if (ax_r == 3'd2) delta = negz / 8;
    else delta = avg[31] ? gq : -gq;
    nsum = 32'(off_r[ax_r]) + delta_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= imu_cal_pkg::ST_ACC;
      cnt_r <= '0; ax_r <= 3'd0; ov_r <= 1'b0; mask_r <= '0;
      for (int i = 0; i < A; i++) begin
        sum_r[i] <= '0; best_r[i] <= imu_cal_pkg::BEST_RESET; off_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (take) begin
        cnt_r <= cnt_new;
        ax_r  <= 3'd0;
        mask_r <= '0;
        for (int i = 0; i < A; i++) begin
          sum_r[i] <= sum_new[i];
          if (q_item.start) begin
            best_r[i] <= imu_cal_pkg::BEST_RESET;
            off_r[i]  <= init_off[i];
          end
        end
      end
      if (st_r == imu_cal_pkg::ST_DIV && div_done) begin
        mag_r   <= mag;
        delta_r <= delta;
      end
      if (st_r == imu_cal_pkg::ST_UPD) begin
        ax_r <= ax_r + 3'd1;
        sum_r[ax_r] <= '0;
        if (mag_r < 32'(best_r[ax_r])) begin
          best_r[ax_r] <= mag_r[16:0];
          mask_r[ax_r] <= 1'b1;
          off_r[ax_r] <= (nsum > 32767) ? 16'sh7fff :
                         (nsum < -32768) ? 16'sh8000 : nsum[15:0];
        end
      end
      if (st_r == imu_cal_pkg::ST_OUT && !ov_r) begin
        cnt_r <= '0;
        ov_r  <= 1'b1;
        for (int i = 0; i < A; i++) out_res.off[i] <= off_r[i];
        out_res.mask <= mask_r;
      end
    end
  end

  assign out_valid = ov_r;
endmodule

### rtl/imu_offset_calibrator.sv
// Each item is registered in the input queue before the back end takes it;
// non-final samples are taken while the back end accumulates. A round-ending
// sample runs a 33-step serial division plus a done and an update step for
// each of the 6 axes, then a result load. Input queue holds 2 items; sampling
// goes on while a result waits; the next one loads once that one is taken.
// Reset (rst_n low, synchronous): registers to defaults, queue empty.
//------------------------------------------------------------------------------
// imu_offset_calibrator
// Top level: APB registers, input queue, accumulate/divide back end.
//------------------------------------------------------------------------------
module imu_offset_calibrator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // accel x,y,z, gyro x,y,z
  input  logic        in_tuser,  // start_new
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata, // offset accel x,y,z, gyro x,y,z
  output logic [7:0]  out_tuser, // improved_mask, 2 zero bits
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [15:0] rs_r;
  imu_cal_pkg::s16_t [imu_cal_pkg::AXES-1:0] io_r;
  imu_cal_pkg::item_t in_item, q_item;
  imu_cal_pkg::result_t res;
  logic q_valid, q_pop;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= 16'd250; io_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (ridx == imu_cal_pkg::REG_ROUND) rs_r <= cfg_pwdata[15:0];
      else if (ridx <= 3'(imu_cal_pkg::AXES)) io_r[ridx - 3'd1] <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (ridx == imu_cal_pkg::REG_ROUND) cfg_prdata = {16'd0, rs_r};
    else if (ridx <= 3'(imu_cal_pkg::AXES))
      cfg_prdata = 32'(signed'(io_r[ridx - 3'd1]));
  end

  always_comb begin
    in_item.start = in_tuser;
    for (int i = 0; i < imu_cal_pkg::AXES; i++) in_item.smp[i] = in_tdata[16*i +: 16];
  end

  imu_cal_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  imu_cal_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .round_samples(rs_r), .init_off(io_r), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_res(res)
  );

  always_comb begin
    for (int i = 0; i < imu_cal_pkg::AXES; i++) out_tdata[16*i +: 16] = res.off[i];
    out_tuser = {2'b00, res.mask};
  end
endmodule

### rtl/imu_cal_checker.sv
//------------------------------------------------------------------------------
// imu_cal_checker
// Port-level checks for the calibrator, bound to the top level.
//------------------------------------------------------------------------------
module imu_cal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [7:0]  out_tuser,
  input logic        cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result not held");
  a_pad: assert property (@(posedge clk) out_tuser[7:6] == 2'b00)
    else $error("tuser pad set");
  a_rdy: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("back to back results");
endmodule

bind imu_offset_calibrator imu_cal_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .cfg_pready(cfg_pready)
);
